### hw/rtl/flvs_pkg.sv
// shared types and constants of the force layout vertex step block
`default_nettype none

package flvs_pkg;

   // field widths
   localparam int POS_W     = 24;
   localparam int GAIN_W    = 24;
   localparam int VTX_W     = 8;
   localparam int OP_W      = 2;
   localparam int CSR_IDX_W = 3;
   localparam int CNT_CSR_W = 9;

   // datapath widths
   localparam int DIFF_W = POS_W + 1;
   localparam int SQ_W   = 2 * DIFF_W;
   localparam int QUO_W  = POS_W + 9;
   localparam int ACC_W  = 64;
   localparam int MUL_W  = 32;

   // arithmetic constants
   localparam int SPEED_FLOOR = 512;
   localparam int EDGE_MARGIN = 5120;
   localparam int DEG_BIAS    = 1;

   // operation codes
   localparam logic [OP_W-1:0] OP_WRITE_VERTEX = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE_EDGE   = 2'd1;
   localparam logic [OP_W-1:0] OP_STEP         = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FORCE_ENABLE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN         = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DIVISOR      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT         = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT        = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TOP          = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_BOTTOM       = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_COUNT = 3'd7;

   typedef struct packed {
      logic [OP_W-1:0]         operation;
      logic [VTX_W-1:0]        vertex;
      logic [VTX_W-1:0]        other_vertex;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic                    flag;
   } req_type;

   typedef struct packed {
      logic signed [POS_W-1:0] new_x;
      logic signed [POS_W-1:0] new_y;
      logic                    moved;
   } rsp_type;

endpackage

`default_nettype wire

### hw/rtl/flvs_div.sv
// restoring unsigned divider, one quotient bit per cycle
`default_nettype none

module flvs_div #(
   parameter int DEN_W = 50,
   parameter int QUO_W = 33
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic [QUO_W+DEN_W-1:0]   num,
   input  wire logic [DEN_W-1:0]         den,
   output logic                          done,
   output logic [QUO_W-1:0]              quo
);

   localparam int CW = $clog2(QUO_W + 1);

   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [QUO_W-1:0] quo_ff;
   logic [CW-1:0]    cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DEN_W:0]   shifted;
   logic [DEN_W:0]   trial;
   logic             fits;

   // one trial subtraction per cycle
   assign shifted = {rem_ff, quo_ff[QUO_W-1]};
   assign fits    = shifted >= {1'b0, den_ff};
   assign trial   = shifted - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            // quotient fits QUO_W bits, so the top part is below the divisor
            rem_ff  <= num[QUO_W+DEN_W-1:QUO_W];
            quo_ff  <= num[QUO_W-1:0];
            den_ff  <= den;
            cnt_ff  <= CW'(QUO_W);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
            quo_ff <= {quo_ff[QUO_W-2:0], fits};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

`default_nettype wire

### hw/rtl/force_layout_vertex_step.sv
// force directed layout engine: vertex store, edge table and step sequencer
//
// Input channel req_* carries one operation per transfer: write a vertex,
// write an edge bit or step a vertex. Every operation gives exactly one
// transfer on the result channel rsp_*: the vertex position after the
// operation and a moved bit. Registers are written over csr_*, which is
// always ready; the user must write them only while the block is idle,
// which the block itself does not enforce. One operation is in flight
// at a time. A vertex write goes from idle straight to the done state;
// an edge write or a step that does not run passes a lookup state first.
// A running step walks the vertices in use twice through the position
// memories: the first walk runs two repulsion divisions for each vertex
// at nonzero distance, the second two attraction divisions for each
// neighbour, all on the shared bit-serial divider. Positions are Q15.8.
// After reset the adjacency and fixed-mark memories are swept clear, one
// row a cycle over all MAX_VERTICES rows, with req_stall high meanwhile.
// The result sits in an output register; while the receiver stalls a new
// item is still taken, and its result waits until the register empties.
`default_nettype none

module force_layout_vertex_step
   import flvs_pkg::*;
#(
   parameter int MAX_VERTICES = 256
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire req_type                req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output rsp_type                     rsp_data,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [GAIN_W-1:0]      csr_data
);

   localparam int VW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CNT_W = $clog2(MAX_VERTICES + 1);
   localparam int DEG_W = $clog2(2 * MAX_VERTICES + 2);
   localparam int W_W   = DEG_W + GAIN_W;
   localparam int DEN_W = (SQ_W > W_W) ? SQ_W : W_W;
   localparam int NUM_W = QUO_W + DEN_W;
   localparam logic signed [ACC_W-1:0] FLOOR_HI = ACC_W'(SPEED_FLOOR);
   localparam logic signed [ACC_W-1:0] FLOOR_LO = -FLOOR_HI;
   localparam logic signed [ACC_W-1:0] POS_MAX  = ACC_W'((64'sd1 <<< (POS_W - 1)) - 1);
   localparam logic signed [ACC_W-1:0] POS_MIN  = -POS_MAX - 1;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_LOOK,
      ST_P1_RD, ST_P1_DIF, ST_P1_SQX, ST_P1_SQY, ST_P1_SUM, ST_P1_CHK,
      ST_P1_DVX, ST_P1_DVY, ST_W_MUL, ST_P2_W,
      ST_P2_RD, ST_P2_DIF, ST_P2_SX, ST_P2_DVX, ST_P2_DVY,
      ST_FIN_ADD, ST_FIN_CLAMP, ST_FIN_SAT, ST_DONE
   } state_type;

   // configuration registers
   logic                     force_enable_ff;
   logic [GAIN_W-1:0]        gain_ff;
   logic [GAIN_W-1:0]        divisor_ff;
   logic signed [POS_W-1:0]  left_ff;
   logic signed [POS_W-1:0]  right_ff;
   logic signed [POS_W-1:0]  top_ff;
   logic signed [POS_W-1:0]  bottom_ff;
   logic [CNT_CSR_W-1:0]     vertex_count_ff;

   // memories
   logic signed [POS_W-1:0]  x_mem [MAX_VERTICES];
   logic signed [POS_W-1:0]  y_mem [MAX_VERTICES];
   logic                     fixed_mem [MAX_VERTICES];
   logic [MAX_VERTICES-1:0]  out_mem [MAX_VERTICES];
   logic [MAX_VERTICES-1:0]  in_mem [MAX_VERTICES];
   logic signed [POS_W-1:0]  x_rd_ff;
   logic signed [POS_W-1:0]  y_rd_ff;
   logic                     fixed_rd_ff;
   logic [MAX_VERTICES-1:0]  out_row_ff;
   logic [MAX_VERTICES-1:0]  in_row_ff;

   // sequencer state
   state_type                state_ff;
   logic [VW-1:0]            clr_ff;
   logic [VW-1:0]            v_ff;
   logic [OP_W-1:0]          op_ff;
   logic                     flag_ff;
   logic [CNT_W-1:0]         j_ff;
   logic [DEG_W-1:0]         deg_ff;
   logic [1:0]               reps_ff;
   logic signed [POS_W-1:0]  xv_ff;
   logic signed [POS_W-1:0]  yv_ff;
   logic [DIFF_W-1:0]        ax_ff;
   logic [DIFF_W-1:0]        ay_ff;
   logic                     sx_ff;
   logic                     sy_ff;
   logic [SQ_W-1:0]          d2_ff;
   logic [W_W-1:0]           w_ff;
   logic [2*MUL_W-1:0]       prod_ff;
   logic signed [ACC_W-1:0]  xs_ff;
   logic signed [ACC_W-1:0]  ys_ff;
   logic signed [ACC_W-1:0]  px_ff;
   logic signed [ACC_W-1:0]  py_ff;
   logic signed [POS_W-1:0]  res_x_ff;
   logic signed [POS_W-1:0]  res_y_ff;
   logic                     res_moved_ff;
   logic                     rsp_valid_ff;
   rsp_type                  rsp_data_ff;

   // combinational helpers
   logic                     accept;
   logic [VW-1:0]            req_vtx;
   logic [VW-1:0]            req_oth;
   logic                     vtx_ok;
   logic                     oth_ok;
   logic [CNT_W-1:0]         cnt;
   logic [GAIN_W-1:0]        div_eff;
   logic [VW-1:0]            rd_addr;
   logic                     row_load;
   logic                     row_shift;
   logic                     xy_we;
   logic [VW-1:0]            xy_wa;
   logic signed [POS_W-1:0]  x_wd;
   logic signed [POS_W-1:0]  y_wd;
   logic [MUL_W-1:0]         mul_a;
   logic [MUL_W-1:0]         mul_b;
   logic                     div_start;
   logic [NUM_W-1:0]         div_num;
   logic [DEN_W-1:0]         div_den;
   logic                     div_done;
   logic [QUO_W-1:0]         div_quo;
   logic signed [ACC_W-1:0]  q_ext;
   logic signed [ACC_W-1:0]  term_x;
   logic signed [ACC_W-1:0]  term_y;
   logic signed [DIFF_W-1:0] dx;
   logic signed [DIFF_W-1:0] dy;
   logic                     last_j;
   logic                     step_go;
   logic                     out_free;
   logic signed [POS_W-1:0]  sat_x;
   logic signed [POS_W-1:0]  sat_y;

   // clamp into the scene box, lower edge first so the upper edge wins
   function automatic logic signed [ACC_W-1:0] clamp_box(
      input logic signed [ACC_W-1:0] p,
      input logic signed [POS_W-1:0] lo_edge,
      input logic signed [POS_W-1:0] hi_edge
   );
      logic signed [ACC_W-1:0] lo;
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] r;
      lo = ACC_W'(lo_edge) + ACC_W'(EDGE_MARGIN);
      hi = ACC_W'(hi_edge) - ACC_W'(EDGE_MARGIN);
      r  = p;
      if (r < lo) r = lo;
      if (r > hi) r = hi;
      return r;
   endfunction

   // saturate to the position range
   function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [ACC_W-1:0] p);
      logic signed [ACC_W-1:0] r;
      r = p;
      if (r < POS_MIN) r = POS_MIN;
      if (r > POS_MAX) r = POS_MAX;
      return r[POS_W-1:0];
   endfunction

   // handshakes
   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // request decode
   assign req_vtx = VW'(req_data.vertex);
   assign req_oth = VW'(req_data.other_vertex);
   assign vtx_ok  = 32'(req_data.vertex) < MAX_VERTICES;
   assign oth_ok  = 32'(req_data.other_vertex) < MAX_VERTICES;
   assign cnt     = (32'(vertex_count_ff) > MAX_VERTICES) ? CNT_W'(MAX_VERTICES)
                                                          : CNT_W'(vertex_count_ff);
   assign div_eff = (divisor_ff == '0) ? GAIN_W'(1) : divisor_ff;
   assign last_j  = (j_ff + 1'b1) == cnt;
   assign step_go = (op_ff == OP_STEP) && (32'(v_ff) < 32'(cnt)) && force_enable_ff
                    && !fixed_rd_ff && !flag_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         force_enable_ff <= 1'b1;
         gain_ff         <= GAIN_W'(38400);
         divisor_ff      <= GAIN_W'(2560);
         left_ff         <= -POS_W'(256000);
         right_ff        <= POS_W'(256000);
         top_ff          <= -POS_W'(256000);
         bottom_ff       <= POS_W'(256000);
         vertex_count_ff <= CNT_CSR_W'(1);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FORCE_ENABLE: force_enable_ff <= csr_data[0];
            CSR_GAIN:         gain_ff         <= csr_data;
            CSR_DIVISOR:      divisor_ff      <= csr_data;
            CSR_LEFT:         left_ff         <= csr_data;
            CSR_RIGHT:        right_ff        <= csr_data;
            CSR_TOP:          top_ff          <= csr_data;
            CSR_BOTTOM:       bottom_ff       <= csr_data;
            CSR_VERTEX_COUNT: vertex_count_ff <= csr_data[CNT_CSR_W-1:0];
            default:          force_enable_ff <= force_enable_ff;
         endcase
      end
   end

   // memory address and write control
   always_comb begin
      case (state_ff)
         ST_IDLE:            rd_addr = req_vtx;
         ST_P1_RD, ST_P2_RD: rd_addr = j_ff[VW-1:0];
         default:            rd_addr = v_ff;
      endcase
      row_load  = accept || (state_ff == ST_W_MUL);
      row_shift = (state_ff == ST_P1_DIF) || (state_ff == ST_P2_RD);
      xy_we     = (accept && vtx_ok && (req_data.operation == OP_WRITE_VERTEX))
                  || (state_ff == ST_FIN_SAT);
      xy_wa     = (state_ff == ST_IDLE) ? req_vtx : v_ff;
      x_wd      = (state_ff == ST_IDLE) ? req_data.pos_x : sat_x;
      y_wd      = (state_ff == ST_IDLE) ? req_data.pos_y : sat_y;
   end

   assign sat_x = sat_pos(px_ff);
   assign sat_y = sat_pos(py_ff);

   // position memories
   always_ff @(posedge clock) begin
      if (xy_we) begin
         x_mem[xy_wa] <= x_wd;
         y_mem[xy_wa] <= y_wd;
      end
      x_rd_ff <= x_mem[rd_addr];
      y_rd_ff <= y_mem[rd_addr];
   end

   // fixed marks and adjacency rows, outgoing and transposed
   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR) begin
         fixed_mem[clr_ff] <= 1'b0;
         out_mem[clr_ff]   <= '0;
         in_mem[clr_ff]    <= '0;
      end else if (accept && vtx_ok) begin
         if (req_data.operation == OP_WRITE_VERTEX) begin
            fixed_mem[req_vtx] <= req_data.flag;
         end
         if ((req_data.operation == OP_WRITE_EDGE) && oth_ok) begin
            out_mem[req_vtx][req_oth] <= req_data.flag;
            in_mem[req_oth][req_vtx]  <= req_data.flag;
         end
      end
      fixed_rd_ff <= fixed_mem[rd_addr];
      if (row_load) begin
         out_row_ff <= out_mem[rd_addr];
         in_row_ff  <= in_mem[rd_addr];
      end else if (row_shift) begin
         out_row_ff <= out_row_ff >> 1;
         in_row_ff  <= in_row_ff >> 1;
      end
   end

   // shared multiplier, registered
   always_comb begin
      case (state_ff)
         ST_P1_SQY: begin
            mul_a = MUL_W'(ay_ff);
            mul_b = MUL_W'(ay_ff);
         end
         ST_P1_SUM: begin
            mul_a = MUL_W'(ax_ff);
            mul_b = {gain_ff, 8'd0};
         end
         ST_P1_DVX: begin
            mul_a = MUL_W'(ay_ff);
            mul_b = {gain_ff, 8'd0};
         end
         ST_W_MUL: begin
            mul_a = MUL_W'(deg_ff);
            mul_b = MUL_W'(div_eff);
         end
         default: begin
            mul_a = MUL_W'(ax_ff);
            mul_b = MUL_W'(ax_ff);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= (2*MUL_W)'(mul_a) * (2*MUL_W)'(mul_b);
   end

   // divider operands
   always_comb begin
      case (state_ff)
         ST_P1_CHK, ST_P1_DVX: begin
            div_num = NUM_W'(prod_ff);
            div_den = DEN_W'(d2_ff);
         end
         ST_P2_SX: begin
            div_num = NUM_W'({ax_ff, 8'd0});
            div_den = DEN_W'(w_ff);
         end
         default: begin
            div_num = NUM_W'({ay_ff, 8'd0});
            div_den = DEN_W'(w_ff);
         end
      endcase
      div_start = ((state_ff == ST_P1_CHK) && (d2_ff != '0))
                  || ((state_ff == ST_P1_DVX) && div_done)
                  || (state_ff == ST_P2_SX)
                  || ((state_ff == ST_P2_DVX) && div_done);
   end

   flvs_div #(
      .DEN_W (DEN_W),
      .QUO_W (QUO_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   // signed terms from the quotient
   assign q_ext  = ACC_W'(div_quo);
   assign term_x = sx_ff ? -q_ext : q_ext;
   assign term_y = sy_ff ? -q_ext : q_ext;
   assign dx     = DIFF_W'(xv_ff) - DIFF_W'(x_rd_ff);
   assign dy     = DIFF_W'(yv_ff) - DIFF_W'(y_rd_ff);

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // result register: set on hand-over, cleared once taken
         if ((state_ff == ST_DONE) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == VW'(MAX_VERTICES - 1)) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (accept) begin
                  v_ff         <= req_vtx;
                  op_ff        <= req_data.operation;
                  flag_ff      <= req_data.flag;
                  res_moved_ff <= 1'b0;
                  if (!vtx_ok) begin
                     res_x_ff <= '0;
                     res_y_ff <= '0;
                     state_ff <= ST_DONE;
                  end else if (req_data.operation == OP_WRITE_VERTEX) begin
                     res_x_ff <= req_data.pos_x;
                     res_y_ff <= req_data.pos_y;
                     state_ff <= ST_DONE;
                  end else begin
                     state_ff <= ST_LOOK;
                  end
               end
            end
            ST_LOOK: begin
               xv_ff  <= x_rd_ff;
               yv_ff  <= y_rd_ff;
               xs_ff  <= '0;
               ys_ff  <= '0;
               deg_ff <= DEG_W'(DEG_BIAS);
               j_ff   <= '0;
               if (step_go) begin
                  state_ff <= ST_P1_RD;
               end else begin
                  res_x_ff <= x_rd_ff;
                  res_y_ff <= y_rd_ff;
                  state_ff <= ST_DONE;
               end
            end
            // repulsion walk, degree count on the way
            ST_P1_RD: state_ff <= ST_P1_DIF;
            ST_P1_DIF: begin
               ax_ff    <= dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
               ay_ff    <= dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
               sx_ff    <= dx[DIFF_W-1];
               sy_ff    <= dy[DIFF_W-1];
               deg_ff   <= deg_ff + DEG_W'(out_row_ff[0]) + DEG_W'(in_row_ff[0]);
               state_ff <= ST_P1_SQX;
            end
            ST_P1_SQX: state_ff <= ST_P1_SQY;
            ST_P1_SQY: begin
               d2_ff    <= prod_ff[SQ_W-1:0];
               state_ff <= ST_P1_SUM;
            end
            ST_P1_SUM: begin
               d2_ff    <= d2_ff + prod_ff[SQ_W-1:0];
               state_ff <= ST_P1_CHK;
            end
            ST_P1_CHK: begin
               if (d2_ff != '0) begin
                  state_ff <= ST_P1_DVX;
               end else if (last_j) begin
                  state_ff <= ST_W_MUL;
               end else begin
                  j_ff     <= j_ff + 1'b1;
                  state_ff <= ST_P1_RD;
               end
            end
            ST_P1_DVX: begin
               if (div_done) begin
                  xs_ff    <= xs_ff + term_x;
                  state_ff <= ST_P1_DVY;
               end
            end
            ST_P1_DVY: begin
               if (div_done) begin
                  ys_ff <= ys_ff + term_y;
                  if (last_j) begin
                     state_ff <= ST_W_MUL;
                  end else begin
                     j_ff     <= j_ff + 1'b1;
                     state_ff <= ST_P1_RD;
                  end
               end
            end
            // attraction divisor weight, rows reloaded
            ST_W_MUL: state_ff <= ST_P2_W;
            ST_P2_W: begin
               w_ff     <= prod_ff[W_W-1:0];
               j_ff     <= '0;
               state_ff <= ST_P2_RD;
            end
            // attraction walk over neighbours
            ST_P2_RD: begin
               reps_ff <= 2'(out_row_ff[0]) + 2'(in_row_ff[0]);
               if (out_row_ff[0] || in_row_ff[0]) begin
                  state_ff <= ST_P2_DIF;
               end else if (last_j) begin
                  state_ff <= ST_FIN_ADD;
               end else begin
                  j_ff <= j_ff + 1'b1;
               end
            end
            ST_P2_DIF: begin
               ax_ff    <= dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
               ay_ff    <= dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
               sx_ff    <= dx[DIFF_W-1];
               sy_ff    <= dy[DIFF_W-1];
               state_ff <= ST_P2_SX;
            end
            ST_P2_SX: state_ff <= ST_P2_DVX;
            ST_P2_DVX: begin
               if (div_done) begin
                  xs_ff    <= xs_ff - ((reps_ff == 2'd2) ? (term_x <<< 1) : term_x);
                  state_ff <= ST_P2_DVY;
               end
            end
            ST_P2_DVY: begin
               if (div_done) begin
                  ys_ff <= ys_ff - ((reps_ff == 2'd2) ? (term_y <<< 1) : term_y);
                  if (last_j) begin
                     state_ff <= ST_FIN_ADD;
                  end else begin
                     j_ff     <= j_ff + 1'b1;
                     state_ff <= ST_P2_RD;
                  end
               end
            end
            // speed floor, move, clamp, saturate and store
            ST_FIN_ADD: begin
               if ((xs_ff > FLOOR_LO) && (xs_ff < FLOOR_HI)
                   && (ys_ff > FLOOR_LO) && (ys_ff < FLOOR_HI)) begin
                  px_ff <= ACC_W'(xv_ff);
                  py_ff <= ACC_W'(yv_ff);
               end else begin
                  px_ff <= ACC_W'(xv_ff) + xs_ff;
                  py_ff <= ACC_W'(yv_ff) + ys_ff;
               end
               state_ff <= ST_FIN_CLAMP;
            end
            ST_FIN_CLAMP: begin
               px_ff    <= clamp_box(px_ff, left_ff, right_ff);
               py_ff    <= clamp_box(py_ff, top_ff, bottom_ff);
               state_ff <= ST_FIN_SAT;
            end
            ST_FIN_SAT: begin
               res_x_ff     <= sat_x;
               res_y_ff     <= sat_y;
               res_moved_ff <= 1'b1;
               state_ff     <= ST_DONE;
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_data_ff.new_x <= res_x_ff;
                  rsp_data_ff.new_y <= res_y_ff;
                  rsp_data_ff.moved <= res_moved_ff;
                  state_ff          <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

### tb/testbench.sv
// self-checking testbench of the force layout vertex step block
`timescale 1ns / 1ps

module testbench;
   import flvs_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int VERTS = 256;

   // expected vertex positions, worked out from a private copy of the block state
   class position_scoreboard;
      longint   x_tab[VERTS];
      longint   y_tab[VERTS];
      bit       fixed_mark[VERTS];
      bit       adj[VERTS][VERTS];
      bit       enable;
      longint unsigned gain;
      longint unsigned divisor;
      longint   left_edge, right_edge, top_edge, bottom_edge;
      int unsigned count;
      rsp_type  expected_positions[$];
      int       errors;
      int       reported;
      int       compared;

      function new();
         for (int i = 0; i < VERTS; i++) begin
            x_tab[i] = 0;
            y_tab[i] = 0;
            fixed_mark[i] = 0;
            for (int j = 0; j < VERTS; j++) adj[i][j] = 0;
         end
         enable = 1;
         gain = 38400;
         divisor = 2560;
         left_edge = -256000;
         right_edge = 256000;
         top_edge = -256000;
         bottom_edge = 256000;
         count = 1;
         errors = 0;
         reported = 0;
         compared = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [GAIN_W-1:0] val);
         case (idx)
            CSR_FORCE_ENABLE: enable = val[0];
            CSR_GAIN:         gain = val;
            CSR_DIVISOR:      divisor = val;
            CSR_LEFT:         left_edge = longint'($signed(val));
            CSR_RIGHT:        right_edge = longint'($signed(val));
            CSR_TOP:          top_edge = longint'($signed(val));
            CSR_BOTTOM:       bottom_edge = longint'($signed(val));
            CSR_VERTEX_COUNT: count = val[CNT_CSR_W-1:0];
            default: ;
         endcase
      endfunction

      // margin clamp, upper bound last, then saturation to the position range
      function longint clamp_pos(longint p, longint lo, longint hi);
         longint lim;
         lim = longint'(1) <<< (POS_W - 1);
         if (p < lo + EDGE_MARGIN) p = lo + EDGE_MARGIN;
         if (p > hi - EDGE_MARGIN) p = hi - EDGE_MARGIN;
         if (p < -lim) p = -lim;
         if (p > lim - 1) p = lim - 1;
         return p;
      endfunction

      function void move_vertex(int unsigned v, int unsigned cnt);
         longint sx, sy, dx, dy, w, ox, oy;
         longint unsigned ax, ay, g, dv, deg, tx, ty;
         logic [127:0] d2;
         int reps;
         sx = 0;
         sy = 0;
         g = gain << 8;
         dv = (divisor == 0) ? 1 : divisor;
         deg = DEG_BIAS;
         // repulsion from every vertex in use at nonzero distance
         for (int j = 0; j < cnt; j++) begin
            dx = x_tab[v] - x_tab[j];
            dy = y_tab[v] - y_tab[j];
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            d2 = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay);
            if (d2 != 0) begin
               tx = 64'((128'(ax) * 128'(g)) / d2);
               ty = 64'((128'(ay) * 128'(g)) / d2);
               sx += (dx < 0) ? -longint'(tx) : longint'(tx);
               sy += (dy < 0) ? -longint'(ty) : longint'(ty);
            end
         end
         // degree over out and in edges, self-loop counted twice
         for (int j = 0; j < cnt; j++) begin
            if (adj[v][j]) deg++;
            if (adj[j][v]) deg++;
         end
         // attraction along each edge
         w = longint'(deg * dv);
         for (int j = 0; j < cnt; j++) begin
            reps = int'(adj[v][j]) + int'(adj[j][v]);
            ox = (x_tab[v] - x_tab[j]) * 256;
            oy = (y_tab[v] - y_tab[j]) * 256;
            for (int k = 0; k < reps; k++) begin
               sx -= ox / w;
               sy -= oy / w;
            end
         end
         // speed floor on both axes
         if ((sx < SPEED_FLOOR && sx > -SPEED_FLOOR)
             && (sy < SPEED_FLOOR && sy > -SPEED_FLOOR)) begin
            sx = 0;
            sy = 0;
         end
         x_tab[v] = clamp_pos(x_tab[v] + sx, left_edge, right_edge);
         y_tab[v] = clamp_pos(y_tab[v] + sy, top_edge, bottom_edge);
      endfunction

      function void note_request(req_type rq);
         rsp_type r;
         int unsigned v, o, cnt;
         v = rq.vertex;
         o = rq.other_vertex;
         cnt = (count > VERTS) ? VERTS : count;
         r.moved = 1'b0;
         case (rq.operation)
            OP_WRITE_VERTEX: begin
               x_tab[v] = longint'($signed(rq.pos_x));
               y_tab[v] = longint'($signed(rq.pos_y));
               fixed_mark[v] = rq.flag;
            end
            OP_WRITE_EDGE: adj[v][o] = rq.flag;
            OP_STEP: begin
               if (v < cnt && enable && !fixed_mark[v] && !rq.flag) begin
                  move_vertex(v, cnt);
                  r.moved = 1'b1;
               end
            end
            default: ;
         endcase
         r.new_x = x_tab[v][POS_W-1:0];
         r.new_y = y_tab[v][POS_W-1:0];
         expected_positions.push_back(r);
      endfunction

      function void check_result(rsp_type got);
         rsp_type exp_r;
         if (expected_positions.size() == 0) begin
            errors++;
            if (reported < 10) begin
               reported++;
               $display("result with nothing expected: x %0d y %0d moved %0b",
                        got.new_x, got.new_y, got.moved);
            end
            return;
         end
         exp_r = expected_positions.pop_front();
         compared++;
         if (got.new_x !== exp_r.new_x || got.new_y !== exp_r.new_y ||
             got.moved !== exp_r.moved) begin
            errors++;
            if (reported < 10) begin
               reported++;
               $display({"mismatch on result %0d: expected x %0d y %0d moved %0b,",
                         " got x %0d y %0d moved %0b"},
                        compared, exp_r.new_x, exp_r.new_y, exp_r.moved,
                        got.new_x, got.new_y, got.moved);
            end
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   rsp_type rsp_data;
   logic csr_valid = 0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [GAIN_W-1:0] csr_data = '0;

   position_scoreboard board = new();
   bit written[VERTS];
   bit quiet = 0;
   int items_sent = 0;
   int results_seen = 0;
   int settings_used = 0;

   force_layout_vertex_step dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #10 clock = ~clock;

   // watchdog
   initial begin
      #200_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // result side: sample between edges, random stall bursts, one long hold-off
   initial begin : result_side
      int gap;
      int hold_cycles;
      bit pressure_done;
      bit take;
      rsp_type got;
      gap = 0;
      hold_cycles = 0;
      pressure_done = 0;
      forever begin
         @(negedge clock);
         take = rsp_valid && !rsp_stall && !reset;
         got = rsp_data;
         @(posedge clock);
         if (take) begin
            board.check_result(got);
            results_seen++;
         end
         if (!pressure_done && results_seen >= 150) begin
            pressure_done = 1;
            hold_cycles = 400;
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_stall <= 1'b1;
         end else if (gap > 0) begin
            gap--;
            rsp_stall <= 1'b1;
         end else if (!quiet && $urandom_range(0, 15) == 0) begin
            gap = $urandom_range(1, 18) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic req_type make_item(logic [OP_W-1:0] op, int v, int o,
                                         int px, int py, bit f);
      req_type it;
      it.operation = op;
      it.vertex = VTX_W'(v);
      it.other_vertex = VTX_W'(o);
      it.pos_x = POS_W'(px);
      it.pos_y = POS_W'(py);
      it.flag = f;
      return it;
   endfunction

   function automatic logic [POS_W-1:0] rand_pos();
      case ($urandom_range(0, 9))
         0: return POS_W'($urandom);
         1: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
         default: return POS_W'($urandom_range(0, 65535) - 32768);
      endcase
   endfunction

   // one input transfer, optionally after an idle burst
   task automatic send_item(req_type it);
      bit took;
      if (!quiet && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= it;
      do begin
         @(negedge clock);
         took = !req_stall;
         @(posedge clock);
      end while (!took);
      board.note_request(it);
      if (it.operation == OP_WRITE_VERTEX) written[it.vertex] = 1;
      items_sent++;
   endtask

   // wait until every expected result has come back
   task automatic settle();
      req_valid <= 1'b0;
      while (board.expected_positions.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [GAIN_W-1:0] val);
      bit took;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do begin
         @(negedge clock);
         took = csr_ready;
         @(posedge clock);
      end while (!took);
      board.write_reg(idx, val);
   endtask

   task automatic set_registers(bit en, int gn, int dv, int l, int r, int t, int b, int cnt);
      settle();
      write_reg(CSR_FORCE_ENABLE, GAIN_W'(en));
      write_reg(CSR_GAIN, GAIN_W'(gn));
      write_reg(CSR_DIVISOR, GAIN_W'(dv));
      write_reg(CSR_LEFT, GAIN_W'(l));
      write_reg(CSR_RIGHT, GAIN_W'(r));
      write_reg(CSR_TOP, GAIN_W'(t));
      write_reg(CSR_BOTTOM, GAIN_W'(b));
      write_reg(CSR_VERTEX_COUNT, GAIN_W'(cnt));
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // random operations on vertices below span, all of them written first
   task automatic run_phase(int n_items, int span, int step_cap);
      req_type it;
      int r;
      int steps_left;
      steps_left = step_cap;
      for (int v = 0; v < span; v++)
         if (!written[v])
            send_item(make_item(OP_WRITE_VERTEX, v, $urandom, rand_pos(), rand_pos(), 0));
      for (int n = 0; n < n_items; n++) begin
         r = $urandom_range(0, 99);
         it = make_item(OP_WRITE_EDGE, $urandom_range(0, span - 1), $urandom,
                        rand_pos(), rand_pos(), $urandom_range(0, 3) != 0);
         if ($urandom_range(0, 9) < 7) it.other_vertex = VTX_W'($urandom_range(0, span - 1));
         if (r < 22) begin
            it.operation = OP_WRITE_VERTEX;
            it.flag = ($urandom_range(0, 6) == 0);
         end else if (r >= 55 && r < 95 && steps_left > 0) begin
            it.operation = OP_STEP;
            it.flag = ($urandom_range(0, 9) == 0);
            steps_left--;
         end else if (r >= 95) begin
            it.operation = OP_UNUSED;
         end
         send_item(it);
      end
   endtask

   initial begin : stimulus
      int cnt;
      int a, b;
      for (int i = 0; i < VERTS; i++) written[i] = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: lone vertex, extreme positions, edges, self-loop, skipped steps
      send_item(make_item(OP_WRITE_VERTEX, 0, 0, 0, 0, 0));
      send_item(make_item(OP_STEP, 0, 0, 0, 0, 0));
      send_item(make_item(OP_UNUSED, 0, 0, 0, 0, 0));
      send_item(make_item(OP_WRITE_VERTEX, 0, 0, 24'h7FFFFF, 24'h800000, 0));
      send_item(make_item(OP_STEP, 0, 0, 0, 0, 0));
      set_registers(1, 38400, 2560, -256000, 256000, -256000, 256000, 4);
      send_item(make_item(OP_WRITE_VERTEX, 1, 0, 2560, 0, 0));
      send_item(make_item(OP_WRITE_VERTEX, 2, 0, 0, -2560, 0));
      send_item(make_item(OP_WRITE_VERTEX, 3, 0, -2560, 2560, 1));
      send_item(make_item(OP_WRITE_VERTEX, 5, 0, 1000, 1000, 0));
      send_item(make_item(OP_WRITE_EDGE, 0, 1, 0, 0, 1));
      send_item(make_item(OP_WRITE_EDGE, 2, 0, 0, 0, 1));
      send_item(make_item(OP_WRITE_EDGE, 0, 0, 0, 0, 1));
      send_item(make_item(OP_WRITE_EDGE, 0, 200, 0, 0, 1));
      send_item(make_item(OP_WRITE_EDGE, 1, 3, 0, 0, 0));
      send_item(make_item(OP_STEP, 0, 0, 0, 0, 0));
      send_item(make_item(OP_STEP, 1, 0, 0, 0, 0));
      send_item(make_item(OP_STEP, 2, 0, 0, 0, 1));
      send_item(make_item(OP_STEP, 3, 0, 0, 0, 0));
      send_item(make_item(OP_STEP, 5, 0, 0, 0, 0));
      send_item(make_item(OP_UNUSED, 1, 0, 0, 0, 0));
      send_item(make_item(OP_STEP, 0, 0, 0, 0, 0));

      // random phases under a range of register settings
      for (int p = 0; p < 12; p++) begin
         cnt = $urandom_range(2, 7);
         case (p)
            0: set_registers(1, 38400, 2560, -256000, 256000, -256000, 256000, 4);
            1: set_registers(1, 0, 0, -256000, 256000, -256000, 256000, 3);
            2: set_registers(1, 24'hFFFFFF, 24'hFFFFFF, 24'h800000, 24'h7FFFFF,
                             24'h800000, 24'h7FFFFF, 5);
            3: set_registers(1, 38400, 2560, -256000, 256000, -256000, 256000, VERTS);
            4: set_registers(0, 38400, 2560, -256000, 256000, -256000, 256000, 4);
            5: set_registers(1, 38400, 1, 100000, -100000, 5000, -5000, 6);
            6: set_registers(1, 38400, 2560, -256000, 256000, -256000, 256000, 0);
            8: set_registers(1, 9000, 700, -50000, 50000, -50000, 50000, 400);
            11: set_registers(1, 38400, 2560, -256000, 256000, -256000, 256000, 8);
            default: begin
               a = $urandom_range(0, 300000) - 150000;
               b = a + $urandom_range(0, 300000);
               set_registers(1, $urandom, $urandom, a, b, -b, -a, cnt);
            end
         endcase
         if (p == 11) quiet = 1;
         case (p)
            3: run_phase(75, VERTS, 3);
            8: run_phase(75, VERTS, 1);
            0, 1, 2, 4, 5: run_phase(75, (p == 2) ? 7 : 8, 1000);
            11: run_phase(75, 10, 1000);
            default: run_phase(75, cnt + 2, 1000);
         endcase
      end

      // drain and close
      settle();
      repeat (20) @(posedge clock);
      if (board.expected_positions.size() != 0) begin
         board.errors += board.expected_positions.size();
         $display("%0d expected results never arrived", board.expected_positions.size());
      end
      $display("sent %0d operations under %0d register settings", items_sent, settings_used);
      $display("compared %0d results, %0d failures", board.compared, board.errors);
      if (board.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### files.f
hw/rtl/flvs_pkg.sv
hw/rtl/flvs_div.sv
hw/rtl/force_layout_vertex_step.sv
tb/testbench.sv
